FILE: sv/aes_pkg.sv
// aes_pkg: shared types and constants for the escape sequence stripper
// no dependencies; used by aes_parse, aes_out_stage and ansi_escape_stripper_top

package aes_pkg;

    typedef logic [2:0] t_state;
    typedef logic [7:0] t_byte;
    typedef logic [6:0] t_char;

    // parser states
    localparam t_state ST_GROUND  = 3'd0;
    localparam t_state ST_ESC     = 3'd1;
    localparam t_state ST_CSI     = 3'd2;
    localparam t_state ST_OSC     = 3'd3;
    localparam t_state ST_OSC_W   = 3'd4;
    localparam t_state ST_OSC_P   = 3'd5;
    localparam t_state ST_OSC_STR = 3'd6;
    localparam t_state ST_OSC_ST  = 3'd7;

    // byte codes
    localparam t_byte CH_BEL       = 8'h07;
    localparam t_byte CH_LF        = 8'h0A;
    localparam t_byte CH_CR        = 8'h0D;
    localparam t_byte CH_ESC       = 8'h1B;
    localparam t_byte CH_DEL       = 8'h7F;
    localparam t_byte CH_INTER_LO  = 8'h20;
    localparam t_byte CH_INTER_HI  = 8'h2F;
    localparam t_byte CH_DIGIT_LO  = 8'h30;
    localparam t_byte CH_DIGIT_HI  = 8'h39;
    localparam t_byte CH_SEMI      = 8'h3B;
    localparam t_byte CH_AT        = 8'h40;
    localparam t_byte CH_P         = 8'h50;
    localparam t_byte CH_R         = 8'h52;
    localparam t_byte CH_W         = 8'h57;
    localparam t_byte CH_LBRACKET  = 8'h5B;
    localparam t_byte CH_BACKSLASH = 8'h5C;
    localparam t_byte CH_RBRACKET  = 8'h5D;

    // parser step result
    typedef struct packed {
        t_state state;
        logic   inter;
        logic   emit;
    } t_parse_res;

endpackage

FILE: sv/aes_parse.sv
// aes_parse: next-state function of the escape sequence parser for one byte
// depends on aes_pkg

module aes_parse (
    input  aes_pkg::t_state     i_state,
    input  logic                i_inter,
    input  aes_pkg::t_byte      i_byte,
    output aes_pkg::t_parse_res o_res
);

    logic is_digit;
    logic is_inter;
    logic do_after_esc;

    assign is_digit = (i_byte >= aes_pkg::CH_DIGIT_LO) && (i_byte <= aes_pkg::CH_DIGIT_HI);
    assign is_inter = (i_byte >= aes_pkg::CH_INTER_LO) && (i_byte <= aes_pkg::CH_INTER_HI);

    always_comb begin
        o_res.state  = i_state;
        o_res.inter  = i_inter;
        o_res.emit   = 1'b0;
        do_after_esc = 1'b0;
        if (i_byte >= aes_pkg::CH_DEL) begin
            // dropped, state untouched
        end else if (i_byte == aes_pkg::CH_ESC && i_state <= aes_pkg::ST_OSC_W) begin
            o_res.state = aes_pkg::ST_ESC;
            o_res.inter = 1'b0;
        end else begin
            unique case (i_state)
                aes_pkg::ST_GROUND: begin
                    o_res.emit = 1'b1;
                end
                aes_pkg::ST_OSC_ST: begin
                    if (i_byte == aes_pkg::CH_BACKSLASH) begin
                        o_res.state = aes_pkg::ST_GROUND;
                    end else begin
                        do_after_esc = 1'b1;
                    end
                end
                aes_pkg::ST_ESC: begin
                    do_after_esc = 1'b1;
                end
                aes_pkg::ST_CSI: begin
                    if (is_digit || i_byte == aes_pkg::CH_SEMI) begin
                        // parameter byte
                    end else if (i_byte < aes_pkg::CH_AT) begin
                        o_res.inter = 1'b1;
                    end else begin
                        o_res.state = aes_pkg::ST_GROUND;
                    end
                end
                aes_pkg::ST_OSC: begin
                    if (i_byte == aes_pkg::CH_P) begin
                        o_res.state = aes_pkg::ST_OSC_P;
                    end else if (i_byte == aes_pkg::CH_R) begin
                        o_res.state = aes_pkg::ST_GROUND;
                    end else if (i_byte == aes_pkg::CH_W) begin
                        o_res.state = aes_pkg::ST_OSC_W;
                    end else if (!is_digit) begin
                        o_res.state = aes_pkg::ST_OSC_STR;
                    end
                end
                aes_pkg::ST_OSC_W: begin
                    if (!is_digit) begin
                        o_res.state = aes_pkg::ST_OSC_STR;
                    end
                end
                aes_pkg::ST_OSC_P: begin
                    o_res.state = aes_pkg::ST_GROUND;
                end
                aes_pkg::ST_OSC_STR: begin
                    if (i_byte == aes_pkg::CH_LF || i_byte == aes_pkg::CH_CR ||
                        i_byte == aes_pkg::CH_BEL) begin
                        o_res.state = aes_pkg::ST_GROUND;
                    end else if (i_byte == aes_pkg::CH_ESC) begin
                        o_res.state = aes_pkg::ST_OSC_ST;
                    end
                end
                default: begin
                    o_res.state = aes_pkg::ST_GROUND;
                end
            endcase
        end

        // byte following an escape
        if (do_after_esc) begin
            if (is_inter) begin
                o_res.inter = 1'b1;
            end else begin
                o_res.state = aes_pkg::ST_GROUND;
                if (!i_inter) begin
                    if (i_byte == aes_pkg::CH_LBRACKET) begin
                        o_res.state = aes_pkg::ST_CSI;
                    end else if (i_byte == aes_pkg::CH_RBRACKET) begin
                        o_res.state = aes_pkg::ST_OSC;
                    end
                end
            end
        end
    end

endmodule

FILE: sv/aes_out_stage.sv
// aes_out_stage: one-entry output register for passed-through characters
// depends on aes_pkg

module aes_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aes_pkg::t_char i_char,
    output logic           o_can_take,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output aes_pkg::t_char o_char_out
);

    logic           r_valid;
    aes_pkg::t_char r_char;

    assign o_can_take  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_char_out  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_char <= i_char;
        end
    end

endmodule

FILE: sv/ansi_escape_stripper_top.sv
// ansi_escape_stripper_top: removes terminal escape sequences from a byte stream
// depends on aes_pkg, aes_parse, aes_out_stage
//
// One byte is accepted per cycle, every cycle the output register is empty or being
// drained; the parser state updates in the accepting cycle, so throughput is one byte
// per clock. A plain-text byte appears on the output in the cycle after acceptance.
// Bytes 0x7F and above are dropped, ESC sequences, CSI and OSC included, are consumed
// without output, and a transaction with last_byte set returns the parser to ground.

module ansi_escape_stripper_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_byte_in,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [6:0] o_char_out
);

    aes_pkg::t_state     r_state;
    aes_pkg::t_state     n_state;
    logic                r_inter;
    logic                n_inter;
    aes_pkg::t_parse_res parse_res;
    logic                in_accept;

    aes_parse u_parse (
        .i_state (r_state),
        .i_inter (r_inter),
        .i_byte  (i_byte_in),
        .o_res   (parse_res)
    );

    assign in_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_inter = r_inter;
        if (in_accept) begin
            if (i_last_byte) begin
                n_state = aes_pkg::ST_GROUND;
                n_inter = 1'b0;
            end else begin
                n_state = parse_res.state;
                n_inter = parse_res.inter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::ST_GROUND;
            r_inter <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inter <= n_inter;
        end
    end

    aes_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept && parse_res.emit),
        .i_char      (i_byte_in[6:0]),
        .o_can_take  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_out  (o_char_out)
    );

endmodule
